// File: src/tensor_element_dequantizer_assert.svh
// Assertion macros for the tensor element dequantizer
`ifndef TENSOR_ELEMENT_DEQUANTIZER_ASSERT_SVH
`define TENSOR_ELEMENT_DEQUANTIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define TED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ted_pkg.sv
// Package for the tensor element dequantizer: types, codes and float helpers
package ted_pkg;

  localparam logic [3:0] ET_F32  = 4'd0;
  localparam logic [3:0] ET_F16  = 4'd1;
  localparam logic [3:0] ET_I8   = 4'd2;
  localparam logic [3:0] ET_U8   = 4'd3;
  localparam logic [3:0] ET_I16  = 4'd4;
  localparam logic [3:0] ET_U16  = 4'd5;
  localparam logic [3:0] ET_I32  = 4'd6;
  localparam logic [3:0] ET_U32  = 4'd7;
  localparam logic [3:0] ET_I64  = 4'd8;
  localparam logic [3:0] ET_BOOL = 4'd9;

  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_FIXED  = 2'd1;
  localparam logic [1:0] QM_AFFINE = 2'd2;

  localparam logic [2:0] REG_ELEM_TYPE   = 3'd0;
  localparam logic [2:0] REG_QUANT_MODE  = 3'd1;
  localparam logic [2:0] REG_SCALE_BITS  = 3'd2;
  localparam logic [2:0] REG_ZERO_POINT  = 3'd3;
  localparam logic [2:0] REG_FRAC_LENGTH = 3'd4;

  localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F32_INF  = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [63:0] raw_element;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        unsupported;
    logic        last_out;
  } out_t;

  // Side information that travels down the pipe with each request
  typedef struct packed {
    logic [31:0] byp;
    logic        scaled;
    logic        unsup;
    logic        last;
  } meta_t;

  // Integer sign and magnitude to binary32, round to nearest even
  function automatic logic [31:0] int_to_f32(input logic neg, input logic [63:0] mag);
    logic [5:0]  p;
    logic [63:0] n;
    logic        rup;
    logic [24:0] k;
    logic [7:0]  ex;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = 6'(i);
    end
    n   = mag << (6'd63 - p);
    rup = n[39] & ((|n[38:0]) | n[40]);
    k   = {1'b0, n[63:40]} + 25'(rup);
    ex  = 8'(p) + 8'd127;
    if (k[24]) ex = ex + 8'd1;
    if (mag == '0) return '0;
    return {neg, ex, k[22:0]};
  endfunction

  // Exact widening of binary16
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [3:0]  k;
    logic [3:0]  e;
    logic [9:0]  man;
    logic [4:0]  ex;
    ex  = h[14:10];
    man = h[9:0];
    k   = '0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) k = 4'(i);
    end
    e = 4'd10 - k;
    if (ex == 5'h00) begin
      if (man == '0) return {h[15], 31'h0};
      return {h[15], 8'd113 - 8'(e), 10'(man << e), 13'h0};
    end
    if (ex == 5'h1F) return {h[15], 8'hFF, man, 13'h0};
    return {h[15], 8'(ex) + 8'd112, man, 13'h0};
  endfunction

  // Two to the minus frac as binary32
  function automatic logic [31:0] pow2_neg(input logic signed [7:0] fl);
    logic signed [9:0] e;
    e = -10'(fl);
    if (e > 10'sd127) return F32_INF;
    if (e >= -10'sd126) return {1'b0, 8'(e + 10'sd127), 23'h0};
    return 32'h1 << 5'(e + 10'sd149);
  endfunction

  // Integer-valued binary32 back to its magnitude
  function automatic logic [33:0] f_to_mag(input logic [31:0] f);
    logic [5:0]  e;
    logic [56:0] t;
    e = 6'(f[30:23] - 8'd127);
    t = {33'h0, 1'b1, f[22:0]} << e;
    if (f[30:23] == 8'h00) return '0;
    return t[56:23];
  endfunction

endpackage

// File: src/tensor_element_dequantizer.sv
// Top level of the tensor element dequantizer: raw element to binary32
// Takes one request per cycle while the output is not stalled and returns one binary32 result
// per request on out_valid. The six register stages are:
// integer and half-float decode with zero point and scale selection, exact integer subtract of
// the rounded operands, rounding of the difference, mantissa multiply, product normalisation,
// and final rounding with subnormal and overflow handling. in_ready drops only while the
// output register holds a result that has not been taken. Registers are written through the
// cfg port, which is always ready; write only while the pipe is empty.
module tensor_element_dequantizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ted_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ted_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

`include "tensor_element_dequantizer_assert.svh"

  logic [3:0]  elem_type_r;
  logic [1:0]  quant_mode_r;
  logic [31:0] scale_bits_r;
  logic [31:0] zero_point_r;
  logic [7:0]  frac_length_r;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  assign cfg_ready = 1'b1;
  assign en        = !v6_r || out_ready;
  assign in_ready  = en;
  assign out_valid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r   <= ted_pkg::ET_F32;
      quant_mode_r  <= ted_pkg::QM_NONE;
      scale_bits_r  <= ted_pkg::F32_ONE;
      zero_point_r  <= '0;
      frac_length_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ted_pkg::REG_ELEM_TYPE:   elem_type_r   <= cfg_wdata[3:0];
        ted_pkg::REG_QUANT_MODE:  quant_mode_r  <= cfg_wdata[1:0];
        ted_pkg::REG_SCALE_BITS:  scale_bits_r  <= cfg_wdata;
        ted_pkg::REG_ZERO_POINT:  zero_point_r  <= cfg_wdata;
        ted_pkg::REG_FRAC_LENGTH: frac_length_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r} <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Stage 1: decode element, pick scale and zero point
  logic          neg;
  logic [63:0]   mag;
  logic [63:0]   raw;
  logic [31:0]   xf_nxt, zf_nxt, sf_nxt;
  ted_pkg::meta_t m1_nxt;
  logic [31:0]   xf_r, zf_r, sf1_r;
  ted_pkg::meta_t m1_r;

  always_comb begin
    raw    = in_data.raw_element;
    neg    = 1'b0;
    mag    = '0;
    m1_nxt = '0;
    m1_nxt.last = in_data.last_in;
    case (elem_type_r)
      ted_pkg::ET_I8: begin
        neg = raw[7];
        mag = neg ? 64'(8'(~raw[7:0]) + 9'd1) : 64'(raw[7:0]);
      end
      ted_pkg::ET_U8:  mag = 64'(raw[7:0]);
      ted_pkg::ET_I16: begin
        neg = raw[15];
        mag = neg ? 64'(16'(~raw[15:0]) + 17'd1) : 64'(raw[15:0]);
      end
      ted_pkg::ET_U16: mag = 64'(raw[15:0]);
      ted_pkg::ET_I32: begin
        neg = raw[31];
        mag = neg ? 64'(32'(~raw[31:0]) + 33'd1) : 64'(raw[31:0]);
      end
      ted_pkg::ET_U32: mag = 64'(raw[31:0]);
      ted_pkg::ET_I64: begin
        neg = raw[63];
        mag = neg ? (~raw + 64'd1) : raw;
      end
      default: ;
    endcase
    xf_nxt = ted_pkg::int_to_f32(neg, mag);
    case (elem_type_r)
      ted_pkg::ET_F32:  m1_nxt.byp = raw[31:0];
      ted_pkg::ET_F16:  m1_nxt.byp = ted_pkg::half_to_f32(raw[15:0]);
      ted_pkg::ET_I8, ted_pkg::ET_U8, ted_pkg::ET_I16, ted_pkg::ET_U16,
      ted_pkg::ET_I32, ted_pkg::ET_U32: m1_nxt.scaled = 1'b1;
      ted_pkg::ET_I64:  m1_nxt.byp = xf_nxt;
      ted_pkg::ET_BOOL: m1_nxt.byp = (raw[7:0] != 8'h00) ? ted_pkg::F32_ONE : '0;
      default:          m1_nxt.unsup = 1'b1;
    endcase
    sf_nxt = ted_pkg::F32_ONE;
    zf_nxt = '0;
    if (quant_mode_r == ted_pkg::QM_AFFINE) begin
      sf_nxt = scale_bits_r;
      zf_nxt = ted_pkg::int_to_f32(zero_point_r[31], zero_point_r[31] ?
               64'(32'(~zero_point_r) + 33'd1) : 64'(zero_point_r));
    end else if (quant_mode_r == ted_pkg::QM_FIXED) begin
      sf_nxt = ted_pkg::pow2_neg(frac_length_r);
    end
  end

  // Stage 2: exact difference of the rounded integer operands
  logic signed [35:0] dif;
  logic               dneg_nxt, dneg_r;
  logic [33:0]        dmag_nxt, dmag_r;
  logic [31:0]        sf2_r, sf3_r;
  ted_pkg::meta_t     m2_r, m3_r;

  always_comb begin
    logic signed [35:0] xi, zi;
    xi = $signed({2'b00, ted_pkg::f_to_mag(xf_r)});
    zi = $signed({2'b00, ted_pkg::f_to_mag(zf_r)});
    if (xf_r[31]) xi = -xi;
    if (zf_r[31]) zi = -zi;
    dif      = xi - zi;
    dneg_nxt = dif[35];
    dmag_nxt = dneg_nxt ? 34'(-dif) : 34'(dif);
  end

  // Stage 3: round the difference to binary32
  logic [31:0] df_r;

  // Stage 4: multiply significands, resolve special operands
  logic [47:0]        p_nxt, p_r;
  logic signed [10:0] e_nxt, e_r;
  logic               sg_r;
  ted_pkg::meta_t     m4_nxt, m4_r;

  always_comb begin
    logic s_nan, s_inf, s_zero, d_zero, sg;
    logic [23:0] ms;
    logic [7:0]  es;
    s_nan  = (sf3_r[30:23] == 8'hFF) && (sf3_r[22:0] != '0);
    s_inf  = (sf3_r[30:23] == 8'hFF) && (sf3_r[22:0] == '0);
    s_zero = (sf3_r[30:0] == '0);
    d_zero = (df_r[30:0] == '0);
    sg     = df_r[31] ^ sf3_r[31];
    ms     = (sf3_r[30:23] == 8'h00) ? {1'b0, sf3_r[22:0]} : {1'b1, sf3_r[22:0]};
    es     = (sf3_r[30:23] == 8'h00) ? 8'd1 : sf3_r[30:23];
    p_nxt  = {1'b1, df_r[22:0]} * ms;
    e_nxt  = $signed({3'b000, df_r[30:23]}) + $signed({3'b000, es}) - 11'sd127;
    m4_nxt = m3_r;
    if (m3_r.scaled) begin
      if (s_nan || (s_inf && d_zero)) begin
        m4_nxt.scaled = 1'b0;
        m4_nxt.byp    = ted_pkg::F32_QNAN;
      end else if (s_inf) begin
        m4_nxt.scaled = 1'b0;
        m4_nxt.byp    = {sg, ted_pkg::F32_INF[30:0]};
      end else if (d_zero || s_zero) begin
        m4_nxt.scaled = 1'b0;
        m4_nxt.byp    = {sg, 31'h0};
      end
    end
  end

  // Stage 5: normalise the product
  logic [47:0]        pn_nxt, pn_r;
  logic signed [10:0] xr_nxt, xr_r;
  logic               sg5_r;
  ted_pkg::meta_t     m5_r;

  always_comb begin
    logic [5:0] q;
    q = '0;
    for (int i = 0; i < 48; i++) begin
      if (p_r[i]) q = 6'(i);
    end
    pn_nxt = p_r << (6'd47 - q);
    xr_nxt = e_r - 11'sd46 + $signed({5'b00000, q});
  end

  // Stage 6: round, denormalise, saturate
  logic [31:0] val_nxt;

  always_comb begin
    logic [5:0]  sh;
    logic [10:0] field;
    logic [47:0] qv;
    logic [48:0] mask;
    logic        lost, g, st, rup;
    logic [23:0] mant;
    logic [32:0] sum;
    if (xr_r >= 11'sd1) begin
      sh    = '0;
      field = 11'(xr_r - 11'sd1);
    end else begin
      sh    = (xr_r < -11'sd47) ? 6'd48 : 6'(11'sd1 - xr_r);
      field = '0;
    end
    qv   = pn_r >> sh;
    mask = (49'd1 << sh) - 49'd1;
    lost = |(pn_r & mask[47:0]);
    mant = qv[47:24];
    g    = qv[23];
    st   = (|qv[22:0]) | lost;
    rup  = g & (st | mant[0]);
    sum  = (33'(field) << 23) + 33'(mant) + 33'(rup);
    if (!m5_r.scaled) begin
      val_nxt = m5_r.byp;
    end else if (sum >= 33'(ted_pkg::F32_INF)) begin
      val_nxt = {sg5_r, ted_pkg::F32_INF[30:0]};
    end else begin
      val_nxt = {sg5_r, sum[30:0]};
    end
  end

  ted_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xf_r   <= xf_nxt;
      zf_r   <= zf_nxt;
      sf1_r  <= sf_nxt;
      m1_r   <= m1_nxt;
      dneg_r <= dneg_nxt;
      dmag_r <= dmag_nxt;
      sf2_r  <= sf1_r;
      m2_r   <= m1_r;
      df_r   <= ted_pkg::int_to_f32(dneg_r, 64'(dmag_r));
      sf3_r  <= sf2_r;
      m3_r   <= m2_r;
      p_r    <= p_nxt;
      e_r    <= e_nxt;
      sg_r   <= df_r[31] ^ sf3_r[31];
      m4_r   <= m4_nxt;
      pn_r   <= pn_nxt;
      xr_r   <= xr_nxt;
      sg5_r  <= sg_r;
      m5_r   <= m4_r;
      out_r.value_bits  <= m5_r.unsup ? 32'h0 : val_nxt;
      out_r.unsupported <= m5_r.unsup;
      out_r.last_out    <= m5_r.last;
    end
  end

  assign out_data = out_r;

  `TED_ASSERT_NOW(a_unsup_zero, out_valid && out_data.unsupported, out_data.value_bits == 32'h0, "unsupported result with nonzero value")
  `TED_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1_r, "accepted request missing from first stage")
  `TED_ASSERT_NEXT(a_stall_holds, v6_r && v5_r && !out_ready, v6_r && v5_r, "request lost during stall")

endmodule

// File: verif/ted_checker.sv
// Checker for the tensor element dequantizer: predicts each result and compares it
module ted_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  ted_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  ted_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output int            mismatch_count,
  output int            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [3:0]        elem_type_q;
  logic [1:0]        quant_mode_q;
  logic [31:0]       scale_q;
  logic [31:0]       zero_point_q;
  logic signed [7:0] frac_q;
  ted_pkg::out_t     expected_values[$];

  // Round mag * 2^sh to binary32, nearest even, with subnormals and overflow
  function automatic logic [31:0] round_f32(input logic neg, input logic [63:0] mag,
                                            input int sh);
    int          p;
    int          e;
    int          drop;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    if (mag == '0) return {neg, 31'h0};
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = i;
    end
    e = p + sh;
    drop = (e >= -126) ? p - 23 : -149 - sh;
    if (drop <= 0) begin
      keep = mag << (-drop);
    end else begin
      rem  = mag & ((64'd1 << drop) - 64'd1);
      half = 64'd1 << (drop - 1);
      keep = mag >> drop;
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
    end
    if (e < -126) return {neg, keep[30:0]};
    if (keep == (64'd1 << 24)) begin
      keep = keep >> 1;
      e = e + 1;
    end
    if (e > 127) return {neg, ted_pkg::F32_INF[30:0]};
    return {neg, 8'(e + 127), keep[22:0]};
  endfunction

  function automatic logic [31:0] signed_to_f32(input longint v);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    return round_f32(v < 0, mag, 0);
  endfunction

  // Integer-valued binary32 back to an integer
  function automatic longint f32_to_int(input logic [31:0] b);
    int          e;
    logic [63:0] m;
    if (b[30:23] == 8'h00) return 0;
    e = int'(b[30:23]) - 127;
    m = {40'h0, 1'b1, b[22:0]};
    m = (e >= 23) ? m << (e - 23) : m >> (23 - e);
    return b[31] ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [10:0] m;
    int          e;
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'h0};
    if (h[14:10] != 5'h00) return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'h0};
    if (h[9:0] == '0) return {h[15], 31'h0};
    m = {1'b0, h[9:0]};
    e = 0;
    while (!m[10]) begin
      m = m << 1;
      e++;
    end
    return {h[15], 8'(113 - e), m[9:0], 13'h0};
  endfunction

  function automatic logic [31:0] fixed_scale(input logic signed [7:0] fl);
    int e;
    e = -int'(fl);
    if (e > 127) return ted_pkg::F32_INF;
    if (e >= -126) return {1'b0, 8'(e + 127), 23'h0};
    return 32'd1 << (e + 149);
  endfunction

  // Product of an integer-valued float and the scale
  function automatic logic [31:0] scale_mul(input logic [31:0] d, input logic [31:0] s);
    logic        sg;
    logic [23:0] md;
    logic [23:0] ms;
    int          es;
    sg = d[31] ^ s[31];
    if (s[30:23] == 8'hFF) begin
      if (s[22:0] != '0 || d[30:0] == '0) return ted_pkg::F32_QNAN;
      return {sg, ted_pkg::F32_INF[30:0]};
    end
    if (d[30:0] == '0 || s[30:0] == '0) return {sg, 31'h0};
    md = {1'b1, d[22:0]};
    ms = (s[30:23] == 8'h00) ? {1'b0, s[22:0]} : {1'b1, s[22:0]};
    es = (s[30:23] == 8'h00) ? -126 : int'(s[30:23]) - 127;
    return round_f32(sg, 64'(md) * 64'(ms), int'(d[30:23]) - 127 + es - 46);
  endfunction

  function automatic ted_pkg::out_t dequantize(input ted_pkg::in_t req);
    ted_pkg::out_t res;
    longint        xi;
    logic          scaled;
    logic [31:0]   sb;
    logic [31:0]   zb;
    longint        diff;
    res = '0;
    res.last_out = req.last_in;
    scaled = 1'b1;
    xi = 0;
    case (elem_type_q)
      ted_pkg::ET_F32: begin res.value_bits = req.raw_element[31:0]; scaled = 1'b0; end
      ted_pkg::ET_F16: begin
        res.value_bits = widen_half(req.raw_element[15:0]);
        scaled = 1'b0;
      end
      ted_pkg::ET_I8:  xi = longint'($signed(req.raw_element[7:0]));
      ted_pkg::ET_U8:  xi = longint'(req.raw_element[7:0]);
      ted_pkg::ET_I16: xi = longint'($signed(req.raw_element[15:0]));
      ted_pkg::ET_U16: xi = longint'(req.raw_element[15:0]);
      ted_pkg::ET_I32: xi = longint'($signed(req.raw_element[31:0]));
      ted_pkg::ET_U32: xi = longint'(req.raw_element[31:0]);
      ted_pkg::ET_I64: begin
        res.value_bits = round_f32(req.raw_element[63],
          req.raw_element[63] ? -req.raw_element : req.raw_element, 0);
        scaled = 1'b0;
      end
      ted_pkg::ET_BOOL: begin
        res.value_bits = (req.raw_element[7:0] != '0) ? ted_pkg::F32_ONE : 32'h0;
        scaled = 1'b0;
      end
      default: begin res.unsupported = 1'b1; scaled = 1'b0; end
    endcase
    if (scaled) begin
      sb = ted_pkg::F32_ONE;
      zb = '0;
      if (quant_mode_q == ted_pkg::QM_AFFINE) begin
        sb = scale_q;
        zb = signed_to_f32(longint'($signed(zero_point_q)));
      end else if (quant_mode_q == ted_pkg::QM_FIXED) begin
        sb = fixed_scale(frac_q);
      end
      diff = f32_to_int(signed_to_f32(xi)) - f32_to_int(zb);
      res.value_bits = scale_mul(signed_to_f32(diff), sb);
      if (res.value_bits[30:23] == 8'hFF && res.value_bits[22:0] != '0)
        res.value_bits = ted_pkg::F32_QNAN;
    end
    return res;
  endfunction

  assign pending_count = expected_values.size();

  always @(posedge clk) begin
    ted_pkg::out_t want;
    if (!rst_n) begin
      elem_type_q    <= ted_pkg::ET_F32;
      quant_mode_q   <= ted_pkg::QM_NONE;
      scale_q        <= ted_pkg::F32_ONE;
      zero_point_q   <= '0;
      frac_q         <= '0;
      mismatch_count <= 0;
      expected_values.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ted_pkg::REG_ELEM_TYPE:   elem_type_q  <= cfg_wdata[3:0];
          ted_pkg::REG_QUANT_MODE:  quant_mode_q <= cfg_wdata[1:0];
          ted_pkg::REG_SCALE_BITS:  scale_q      <= cfg_wdata;
          ted_pkg::REG_ZERO_POINT:  zero_point_q <= cfg_wdata;
          ted_pkg::REG_FRAC_LENGTH: frac_q       <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_values.push_back(dequantize(in_data));
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result %h", out_data);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_values.pop_front();
          if (out_data.value_bits !== want.value_bits
              || out_data.unsupported !== want.unsupported
              || out_data.last_out !== want.last_out) begin
            if (mismatch_count < 10)
              $display("mismatch: value %h/%h unsup %b/%b last %b/%b (expected/actual)",
                       want.value_bits, out_data.value_bits, want.unsupported,
                       out_data.unsupported, want.last_out, out_data.last_out);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb_tensor_element_dequantizer.sv
// Testbench top for the tensor element dequantizer: stimulus, stalls and verdict
module tb_tensor_element_dequantizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 44;
  localparam int PER_PHASE      = 25;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ted_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ted_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [31:0]   cfg_wdata;
  int            mismatch_count;
  int            pending_count;
  int            quiet_cycles;
  logic          calm;

  tensor_element_dequantizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ted_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Result-side stalls in bursts, none once calm
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [3:0] et, input logic [1:0] qm, input logic [31:0] sc,
                           input logic [31:0] zp, input logic [7:0] fl);
    write_reg(ted_pkg::REG_ELEM_TYPE, 32'(et));
    write_reg(ted_pkg::REG_QUANT_MODE, 32'(qm));
    write_reg(ted_pkg::REG_SCALE_BITS, sc);
    write_reg(ted_pkg::REG_ZERO_POINT, zp);
    write_reg(ted_pkg::REG_FRAC_LENGTH, 32'(fl));
  endtask

  task automatic send_element(input logic [63:0] raw, input logic last);
    if (!calm && $urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{raw_element: raw, last_in: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold until every request has its result, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_raw();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = 64'($urandom_range(0, 255));
      1: r[7:0] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'h0};
      2: r[15:0] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 5'h1F, 10'($urandom_range(0, 3))};
      3: r[15:0] = {1'($urandom), 5'h00, 10'($urandom)};
      4: r = $urandom_range(0, 1) ? '1 : '0;
      5: r[31:0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return ted_pkg::F32_INF | ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0);
      1: return ted_pkg::F32_QNAN | 32'($urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
      3: return 32'($urandom_range(1, 32'h007F_FFFF));
      4: return 32'h7F7F_FFFF;
      5: return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_zero_point();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed(8'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [3:0] et;
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: sign edges, half-float specials, wide ints, bool, unsupported
    configure(ted_pkg::ET_I8, ted_pkg::QM_AFFINE, 32'h3F00_0000, 32'hFFFF_FF80, 8'h00);
    send_element(64'h80, 1'b0);
    send_element(64'h7F, 1'b0);
    send_element('1, 1'b1);
    send_element(64'h0, 1'b0);
    drain();
    configure(ted_pkg::ET_F16, ted_pkg::QM_NONE, ted_pkg::F32_ONE, 32'h0, 8'h00);
    send_element(64'h7C00, 1'b0);
    send_element(64'hFC00, 1'b0);
    send_element(64'h7E01, 1'b0);
    send_element(64'h0001, 1'b0);
    send_element(64'h83FF, 1'b0);
    send_element(64'h8000, 1'b1);
    drain();
    configure(ted_pkg::ET_I64, ted_pkg::QM_AFFINE, 32'h4000_0000, 32'h7FFF_FFFF, 8'h7F);
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_element('1, 1'b1);
    drain();
    configure(ted_pkg::ET_BOOL, ted_pkg::QM_NONE, ted_pkg::F32_ONE, 32'h0, 8'h00);
    send_element(64'h100, 1'b0);
    send_element(64'h01, 1'b1);
    drain();
    configure(4'd12, ted_pkg::QM_NONE, ted_pkg::F32_ONE, 32'h0, 8'h00);
    send_element('1, 1'b1);
    drain();
    // Fixed point with the scale overflowing to infinity, then a subnormal scale
    configure(ted_pkg::ET_U32, ted_pkg::QM_FIXED, ted_pkg::F32_ONE, 32'h0, 8'h80);
    send_element(64'h0, 1'b0);
    send_element(64'hFFFF_FFFF, 1'b1);
    drain();
    configure(ted_pkg::ET_I32, ted_pkg::QM_FIXED, ted_pkg::F32_ONE, 32'h8000_0000, 8'h7F);
    send_element(64'h8000_0000, 1'b0);
    send_element(64'h7FFF_FFFF, 1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph >= PHASES - 6);
      if (ph == 0) begin
        configure(4'hF, 2'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'h7F);
      end else if (ph == 1) begin
        configure(ted_pkg::ET_F32, ted_pkg::QM_NONE, 32'h0, 32'h8000_0000, 8'h80);
      end else begin
        et = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
        configure(et, 2'($urandom_range(0, 3)), pick_scale(), pick_zero_point(),
                  8'($urandom));
      end
      for (int i = 0; i < PER_PHASE; i++)
        send_element(pick_raw(), $urandom_range(0, 7) == 0);
      drain();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
